>>> hdl/rmsn_pkg.sv
// shared widths and helpers for the rms vector normalizer
`timescale 1ns / 1ps
`default_nettype none
package rmsn_pkg;
    localparam int SampleWidth = 16;
    localparam int EpsWidth    = 24;
    localparam int InvWidth    = 32;
    localparam int SumWidth    = 44;
    localparam int RootWidth   = 22;
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_READ  = 1'b1;
endpackage
`default_nettype wire

>>> hdl/rmsn_serial_math.sv
// bit-serial divide and square root that produce the inverse rms
`timescale 1ns / 1ps
`default_nettype none
module rmsn_serial_math #(
    parameter int CountWidth = 9
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [rmsn_pkg::SumWidth-1:0]  sum,
    input  wire logic [CountWidth-1:0]          count,
    input  wire logic [rmsn_pkg::EpsWidth-1:0]  epsilon,
    output logic                                done,
    output logic [rmsn_pkg::InvWidth-1:0]       inverse
);
    import rmsn_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_ADD, S_SQRT, S_INV, S_DONE} state_t;
    localparam int CntW = 7;

    state_t                state_reg;
    logic [CntW-1:0]       step_reg;
    logic [SumWidth-1:0]   quot_reg;   // dividend shifts out as quotient shifts in
    logic [SumWidth:0]     rem_reg;
    logic [CountWidth-1:0] div_reg;
    logic [SumWidth-1:0]   mean_reg;
    logic [RootWidth-1:0]  root_reg;
    logic [SumWidth+1:0]   srem_reg;
    logic [32:0]           iq_reg;
    logic [RootWidth:0]    irem_reg;
    logic [InvWidth-1:0]   inv_reg;
    logic                  done_reg;

    logic [SumWidth:0]     rem_shift;
    logic [SumWidth:0]     rem_try;
    logic [SumWidth+1:0]   srem_shift;
    logic [SumWidth+1:0]   srem_try;
    logic [RootWidth:0]    irem_shift;
    logic [RootWidth+1:0]  irem_try;

    always_comb
    begin
        rem_shift  = {rem_reg[SumWidth-1:0], quot_reg[SumWidth-1]};
        rem_try    = rem_shift - {{(SumWidth+1-CountWidth){1'b0}}, div_reg};
        srem_shift = {srem_reg[SumWidth-1:0], mean_reg[SumWidth-1:SumWidth-2]};
        srem_try   = srem_shift - {{(SumWidth-RootWidth){1'b0}}, root_reg, 2'b01};
        irem_shift = {irem_reg[RootWidth-1:0], iq_reg[32]};
        irem_try   = {1'b0, irem_shift} - {2'b00, root_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        quot_reg  <= sum;
                        rem_reg   <= '0;
                        div_reg   <= count;
                        step_reg  <= CntW'(SumWidth);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_reg == '0)
                    begin
                        quot_reg  <= '0;
                        state_reg <= S_ADD;
                    end
                    else
                    begin
                        if (!rem_try[SumWidth] || rem_shift[SumWidth])
                        begin
                            rem_reg  <= rem_try;
                            quot_reg <= {quot_reg[SumWidth-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= rem_shift;
                            quot_reg <= {quot_reg[SumWidth-2:0], 1'b0};
                        end
                        step_reg <= step_reg - 1'b1;
                        if (step_reg == CntW'(1))
                            state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    mean_reg  <= quot_reg + {{(SumWidth-EpsWidth){1'b0}}, epsilon};
                    root_reg  <= '0;
                    srem_reg  <= '0;
                    step_reg  <= CntW'(SumWidth/2);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    mean_reg <= {mean_reg[SumWidth-3:0], 2'b00};
                    if (!srem_try[SumWidth+1])
                    begin
                        srem_reg <= srem_try;
                        root_reg <= {root_reg[RootWidth-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= srem_shift;
                        root_reg <= {root_reg[RootWidth-2:0], 1'b0};
                    end
                    if (step_reg == CntW'(1))
                    begin
                        iq_reg    <= {1'b1, 32'd0};
                        irem_reg  <= '0;
                        step_reg  <= CntW'(33);
                        state_reg <= S_INV;
                    end
                    else
                        step_reg <= step_reg - 1'b1;
                end
                S_INV:
                begin
                    if (root_reg == '0 || root_reg == RootWidth'(1))
                    begin
                        inv_reg   <= '1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (!irem_try[RootWidth+1])
                        begin
                            irem_reg <= irem_try[RootWidth:0];
                            iq_reg   <= {iq_reg[31:0], 1'b1};
                        end
                        else
                        begin
                            irem_reg <= irem_shift;
                            iq_reg   <= {iq_reg[31:0], 1'b0};
                        end
                        step_reg <= step_reg - 1'b1;
                        if (step_reg == CntW'(1))
                        begin
                            inv_reg   <= (!irem_try[RootWidth+1]) ? {iq_reg[30:0], 1'b1}
                                                                  : {iq_reg[30:0], 1'b0};
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign inverse = inv_reg;
endmodule
`default_nettype wire

>>> hdl/rms_vector_normalizer_unit.sv
// top level of the rms vector normalizer
`timescale 1ns / 1ps
`default_nettype none
// A word is taken when start is high and busy is low. In a load the accepting cycle
// writes the store and S_SQ then squares the sample 4 bits a cycle into the running
// sum; a load past capacity is dropped unsquared. A load that closes a vector then
// runs the serial divide (44 steps), root (22 steps) and inverse (33 steps, skipped
// when the root is 0 or 1) plus handoff. A read does a store read, forms the 16x16
// product of |x| and |w|, then runs nine shift-add steps that retire 4 bits of that
// product per cycle against the inverse; a failed read returns a registered error
// word. busy is high outside idle; results appear on valid_out for one cycle, and
// the receiver cannot stall them. No clearing pass is needed after reset.
module rms_vector_normalizer_unit #(
    parameter int MAX_ELEMENTS = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            command,
    input  wire logic signed [15:0]              sample,
    input  wire logic signed [15:0]              weight,
    input  wire logic                            end_of_vector,
    output logic                                 valid_out,
    output logic signed [15:0]                   normalized,
    output logic                                 final_result,
    output logic                                 error,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rmsn_pkg::EpsWidth-1:0]   cfg_data
);
    import rmsn_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    typedef enum logic [2:0] {S_IDLE, S_SQ, S_FIN, S_RD, S_MUL1, S_MUL2, S_OUT} state_t;

    logic [31:0] mem [MAX_ELEMENTS];
    state_t              state_reg;
    logic [EpsWidth-1:0] eps_reg;
    logic [SumWidth-1:0] sum_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       ridx_reg;
    logic [InvWidth-1:0] inv_reg;
    logic                ready_reg;
    logic                eov_reg;
    logic [31:0]         rdata_reg;
    logic [3:0]          step_reg;
    logic [63:0]         acc_reg;     // serial accumulator
    logic [63:0]         mcand_reg;
    logic [31:0]         mplier_reg;
    logic                neg_reg;
    logic                valid_reg;
    logic [15:0]         norm_reg;
    logic                fin_reg;
    logic                err_reg;
    logic                math_start;
    logic                math_done;
    logic [InvWidth-1:0] math_inv;

    logic [15:0] absx;
    logic [15:0] absw;
    logic [63:0] part;
    logic [63:0] rnd;
    logic [29:0] yq;

    rmsn_serial_math #(.CountWidth(CW)) u_math (
        .clk(clk), .rst_n(rst_n), .start(math_start), .sum(sum_reg),
        .count(count_reg), .epsilon(eps_reg), .done(math_done), .inverse(math_inv)
    );

    always_comb
    begin
        absx = rdata_reg[31] ? 16'(-rdata_reg[31:16]) : rdata_reg[31:16];
        absw = rdata_reg[15] ? 16'(-rdata_reg[15:0]) : rdata_reg[15:0];
        part = mcand_reg * {60'd0, mplier_reg[3:0]};
        // floor((p + 2^33) / 2^34) for signed p = +-mag
        rnd  = neg_reg ? (acc_reg - 64'h2_0000_0000 + 64'h3_FFFF_FFFF)
                       : (acc_reg + 64'h2_0000_0000);
        yq   = rnd[63:34];
    end

    assign math_start = (state_reg == S_FIN);
    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = (state_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        if (start && !busy && command == CMD_LOAD && !ready_reg
            && count_reg < CW'(MAX_ELEMENTS))
            mem[count_reg[AW-1:0]] <= {sample, weight};
        else if (start && !busy && command == CMD_LOAD && ready_reg)
            mem[0] <= {sample, weight};
        rdata_reg <= mem[ridx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            eps_reg   <= EpsWidth'(17);
            sum_reg   <= '0;
            count_reg <= '0;
            ridx_reg  <= '0;
            inv_reg   <= '0;
            ready_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                eps_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && command == CMD_LOAD)
                    begin
                        eov_reg <= end_of_vector;
                        acc_reg <= '0;
                        mcand_reg  <= {48'd0, sample[15] ? 16'(-sample) : sample};
                        mplier_reg <= {16'd0, sample[15] ? 16'(-sample) : sample};
                        step_reg   <= 4'd4;
                        if (ready_reg)
                        begin
                            ready_reg <= 1'b0;
                            sum_reg   <= '0;
                            count_reg <= CW'(1);
                            ridx_reg  <= '0;
                            state_reg <= S_SQ;
                        end
                        else if (count_reg < CW'(MAX_ELEMENTS))
                        begin
                            count_reg <= count_reg + 1'b1;
                            state_reg <= S_SQ;
                        end
                        else if (end_of_vector)
                            state_reg <= S_FIN;
                    end
                    else if (start)
                    begin
                        if (!ready_reg || ridx_reg >= count_reg)
                        begin
                            valid_reg <= 1'b1;
                            norm_reg  <= '0;
                            fin_reg   <= 1'b0;
                            err_reg   <= 1'b1;
                        end
                        else
                            state_reg <= S_RD;
                    end
                end
                S_SQ:
                begin
                    acc_reg    <= acc_reg + (part << 0);
                    mcand_reg  <= mcand_reg << 4;
                    mplier_reg <= mplier_reg >> 4;
                    step_reg   <= step_reg - 1'b1;
                    if (step_reg == 4'd1)
                    begin
                        sum_reg   <= sum_reg + (acc_reg[SumWidth-1:0] + part[SumWidth-1:0]);
                        state_reg <= eov_reg ? S_FIN : S_IDLE;
                    end
                end
                S_FIN:
                    state_reg <= S_MUL2;
                S_RD:
                    state_reg <= S_MUL1;
                S_MUL1:
                begin
                    // stage one: |x|*|w| then times inverse, 4 bits a cycle
                    acc_reg    <= '0;
                    mcand_reg  <= {32'd0, inv_reg};
                    mplier_reg <= 32'(absx) * 32'(absw);
                    neg_reg    <= rdata_reg[31] ^ rdata_reg[15];
                    step_reg   <= 4'd8;
                    state_reg  <= S_OUT;
                end
                S_MUL2:
                begin
                    if (math_done)
                    begin
                        inv_reg   <= math_inv;
                        ridx_reg  <= '0;
                        ready_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    acc_reg    <= acc_reg + part;
                    mcand_reg  <= mcand_reg << 4;
                    mplier_reg <= mplier_reg >> 4;
                    step_reg   <= step_reg - 1'b1;
                    if (step_reg == 4'd0)
                    begin
                        valid_reg <= 1'b1;
                        err_reg   <= 1'b0;
                        fin_reg   <= (ridx_reg + 1'b1 == count_reg);
                        ridx_reg  <= ridx_reg + 1'b1;
                        if (!neg_reg)
                            norm_reg <= (rnd[63:49] != '0) ? 16'h7FFF : rnd[49:34];
                        else if (yq > 30'd32768)
                            norm_reg <= 16'h8000;
                        else
                            norm_reg <= 16'(-yq[15:0]);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign valid_out    = valid_reg;
    assign normalized   = norm_reg;
    assign final_result = fin_reg;
    assign error        = err_reg;

    a_no_result_while_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_LOAD) |=> !valid_out)
        else $error("result after load word");
    a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("config taken while busy");
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && error) |-> (normalized == 16'sd0 && !final_result))
        else $error("error word carries data");
endmodule
`default_nettype wire
